>>> design/spmf_pkg.sv
// Shared types and constants for the strict priority multi-queue scheduler.
package spmf_pkg;

  localparam int NUM_LEVELS      = 16;
  localparam int SLOTS_PER_LEVEL = 16;
  localparam int TOTAL_SLOTS     = NUM_LEVELS * SLOTS_PER_LEVEL;

  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int SLOT_W = $clog2(SLOTS_PER_LEVEL);
  localparam int CNT_W  = $clog2(SLOTS_PER_LEVEL + 1);
  localparam int ADDR_W = $clog2(TOTAL_SLOTS);

  localparam int PRI_W    = 5;
  localparam int SOCKET_W = 16;
  localparam int TAG_W    = 32;

  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_DEQUEUE = 1'b1;

  typedef enum logic [2:0] {
    ST_ENQUEUED = 3'd0,
    ST_DEQUEUED = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_BAD_PRI  = 3'd4
  } spmf_status_e;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } spmf_back_state_e;

  typedef struct packed {
    logic                command;
    logic [PRI_W-1:0]    priority_req;
    logic [SOCKET_W-1:0] task_socket;
    logic [TAG_W-1:0]    request_tag;
  } spmf_in_t;

  typedef struct packed {
    spmf_status_e        status;
    logic [SOCKET_W-1:0] out_socket;
    logic [TAG_W-1:0]    out_request;
    logic [PRI_W-1:0]    out_priority;
  } spmf_out_t;

  // Command after decode in the front end
  typedef struct packed {
    logic                is_deq;
    logic                bad_pri;
    logic [LVL_W-1:0]    lvl;
    logic [SOCKET_W-1:0] socket;
    logic [TAG_W-1:0]    tag;
  } spmf_cmd_t;

endpackage

>>> design/spmf_front.sv
// Front end: accepts commands, decodes them and buffers them in a two-entry queue.
module spmf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  spmf_pkg::spmf_in_t  in_data_i,
  output logic                cmd_valid_o,
  input  logic                cmd_pop_i,
  output spmf_pkg::spmf_cmd_t cmd_o
);
  import spmf_pkg::*;

  spmf_cmd_t  entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  spmf_cmd_t  dec;

  always_comb begin
    dec.is_deq  = (in_data_i.command == CMD_DEQUEUE);
    dec.bad_pri = (in_data_i.priority_req == '0) ||
                  ({1'b0, in_data_i.priority_req} > (PRI_W + 1)'(NUM_LEVELS));
    dec.lvl     = LVL_W'(in_data_i.priority_req - PRI_W'(1));
    dec.socket  = in_data_i.task_socket;
    dec.tag     = in_data_i.request_tag;
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_pop_i;
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= dec;
    end
  end

endmodule

>>> design/spmf_back.sv
// Back end: per-level ring pointers, task memory and the result register.
module spmf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_pop_o,
  input  spmf_pkg::spmf_cmd_t cmd_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output spmf_pkg::spmf_out_t out_data_o
);
  import spmf_pkg::*;

  localparam int SUM_W = SLOT_W + 1;

  spmf_back_state_e state_q, state_d;

  logic [SLOT_W-1:0] head_q  [NUM_LEVELS];
  logic [CNT_W-1:0]  count_q [NUM_LEVELS];
  logic [SLOT_W-1:0] head_d;
  logic [CNT_W-1:0]  count_d;
  logic              lvl_we;

  logic [SOCKET_W+TAG_W-1:0] mem [TOTAL_SLOTS];
  logic [SOCKET_W+TAG_W-1:0] rd_data_q;
  logic [ADDR_W-1:0]         mem_addr;
  logic                      mem_we, mem_re;

  logic [LVL_W-1:0] rd_lvl_q, rd_lvl_d;
  logic             out_valid_q, out_valid_d;
  spmf_out_t        out_data_q, out_data_d;

  logic [NUM_LEVELS-1:0] nonempty;
  logic                  any_ne;
  logic [LVL_W-1:0]      top_lvl, sel_lvl;
  logic [SLOT_W-1:0]     sel_head, tail, slot;
  logic [CNT_W-1:0]      sel_count;
  logic [SUM_W-1:0]      tail_sum;
  logic                  out_free;

  // Highest nonempty level wins
  always_comb begin
    top_lvl = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      nonempty[l] = (count_q[l] != '0);
      if (nonempty[l]) begin
        top_lvl = LVL_W'(l);
      end
    end
    any_ne = |nonempty;
  end

  assign out_free  = !out_valid_q || !out_stall_i;
  assign cmd_pop_o = (state_q == BK_IDLE) && cmd_valid_i && out_free;

  assign sel_lvl   = cmd_i.is_deq ? top_lvl : cmd_i.lvl;
  assign sel_head  = head_q[sel_lvl];
  assign sel_count = count_q[sel_lvl];
  assign tail_sum  = SUM_W'(sel_head) + SUM_W'(sel_count);
  assign tail      = (tail_sum >= SUM_W'(SLOTS_PER_LEVEL)) ?
                     SLOT_W'(tail_sum - SUM_W'(SLOTS_PER_LEVEL)) : SLOT_W'(tail_sum);
  assign slot      = cmd_i.is_deq ? sel_head : tail;
  assign mem_addr  = ADDR_W'(ADDR_W'(sel_lvl) * ADDR_W'(SLOTS_PER_LEVEL)) + ADDR_W'(slot);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (cmd_pop_o && cmd_i.is_deq && any_ne) begin
          state_d = BK_READ;
        end
      end
      BK_READ: state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // Datapath and result
  always_comb begin
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    lvl_we      = 1'b0;
    head_d      = sel_head;
    count_d     = sel_count;
    rd_lvl_d    = rd_lvl_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    case (state_q)
      BK_IDLE: begin
        if (cmd_pop_o) begin
          out_data_d = '{status: ST_ENQUEUED, out_socket: '0, out_request: '0,
                         out_priority: '0};
          if (!cmd_i.is_deq) begin
            out_valid_d = 1'b1;
            if (cmd_i.bad_pri) begin
              out_data_d.status = ST_BAD_PRI;
            end else if (sel_count == CNT_W'(SLOTS_PER_LEVEL)) begin
              out_data_d.status = ST_FULL;
            end else begin
              mem_we  = 1'b1;
              lvl_we  = 1'b1;
              count_d = sel_count + CNT_W'(1);
            end
          end else if (!any_ne) begin
            out_valid_d       = 1'b1;
            out_data_d.status = ST_EMPTY;
          end else begin
            // result comes out of the registered memory read next cycle
            mem_re   = 1'b1;
            lvl_we   = 1'b1;
            rd_lvl_d = sel_lvl;
            count_d  = sel_count - CNT_W'(1);
            head_d   = (sel_head == SLOT_W'(SLOTS_PER_LEVEL - 1)) ?
                       '0 : sel_head + SLOT_W'(1);
          end
        end
      end
      BK_READ: begin
        out_valid_d = 1'b1;
        out_data_d  = '{status: ST_DEQUEUED,
                        out_socket: rd_data_q[SOCKET_W+TAG_W-1:TAG_W],
                        out_request: rd_data_q[TAG_W-1:0],
                        out_priority: PRI_W'(rd_lvl_q) + PRI_W'(1)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head_q[l]  <= '0;
        count_q[l] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (lvl_we) begin
        head_q[sel_lvl]  <= head_d;
        count_q[sel_lvl] <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_lvl_q   <= rd_lvl_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= {cmd_i.socket, cmd_i.tag};
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> design/strict_priority_multi_fifo.sv
// Strict priority task scheduler: one ring queue per level, highest level served first.
// Each transaction in yields exactly one transaction out, in order. The front end decodes
// commands into a two-entry queue; the back end executes one command at a time. An
// enqueue, a dropped enqueue or a dequeue from an empty pool is done in the idle state;
// a successful dequeue also passes through the read state, as the task memory read is
// registered, and takes no new command there. Sustained rate is one enqueue per cycle
// while the output is not stalled. The task memory needs no clearing: only occupied
// slots are ever read.
module strict_priority_multi_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  spmf_pkg::spmf_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output spmf_pkg::spmf_out_t out_data_o
);
  import spmf_pkg::*;

  spmf_cmd_t cmd;
  logic      cmd_valid;
  logic      cmd_pop;

  spmf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  spmf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
